@@ rtl/clipped_line_rasterizer_defines.svh @@
// Assertion macros for the clipped line rasteriser.
// Needs clk and rst in the scope that uses them.
`ifndef CLIPPED_LINE_RASTERIZER_DEFINES_SVH
`define CLIPPED_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication.
`define CLR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/clr_pkg.sv @@
// Shared types and constants for the clipped line rasteriser.
// No dependencies.
package clr_pkg;

  localparam int WINDOW_WIDTH  = 1024;
  localparam int WINDOW_HEIGHT = 768;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Visible band: strictly inside the middle three fifths.
  localparam logic signed [16:0] X_LO = 17'(WINDOW_WIDTH / 5);
  localparam logic signed [16:0] X_HI = 17'(WINDOW_WIDTH - WINDOW_WIDTH / 5);
  localparam logic signed [16:0] Y_LO = 17'(WINDOW_HEIGHT / 5);
  localparam logic signed [16:0] Y_HI = 17'(WINDOW_HEIGHT - WINDOW_HEIGHT / 5);

  typedef struct packed {
    logic               func;
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic        [23:0] line_color;
  } item_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic        [23:0] pixel_color;
    logic               visible;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic signed [16:0] major_pos;
    logic signed [16:0] minor_pos;
    logic signed [18:0] error_term;
    logic signed [18:0] straight_increment;
    logic signed [18:0] diagonal_increment;
    logic        [15:0] steps_left;
    logic               major_negative;
    logic               minor_negative;
    logic               axes_swapped;
    logic        [23:0] held_color;
  } line_state_t;

endpackage

@@ rtl/clr_setup.sv @@
// Line setup: major axis, step signs, error term and increments from a load item.
// Depends on clr_pkg.
module clr_setup (
  input  clr_pkg::item_t       item,
  output clr_pkg::line_state_t setup
);

  logic signed [16:0] x0, y0, x1, y1;
  logic               xneg, yneg, swap;
  logic signed [16:0] dx, dy, major_start;
  logic        [15:0] dmaj, dmin;
  logic signed [18:0] dmaj19, dmin19;

  always_comb begin
    x0 = 17'(item.x_start);
    y0 = 17'(item.y_start);
    x1 = 17'(item.x_end);
    y1 = 17'(item.y_end);
    xneg = x1 < x0;
    yneg = y1 < y0;
    dx = xneg ? x0 - x1 : x1 - x0;
    dy = yneg ? y0 - y1 : y1 - y0;
    swap = !(dy < dx);
    dmaj = swap ? dy[15:0] : dx[15:0];
    dmin = swap ? dx[15:0] : dy[15:0];
    dmaj19 = {3'b000, dmaj};
    dmin19 = {3'b000, dmin};
    major_start = swap ? y0 : x0;

    setup.axes_swapped       = swap;
    setup.major_negative     = swap ? yneg : xneg;
    setup.minor_negative     = swap ? xneg : yneg;
    setup.major_pos          = major_start + ((swap ? yneg : xneg) ? -17'sd1 : 17'sd1);
    setup.minor_pos          = swap ? x0 : y0;
    setup.straight_increment = dmin19 <<< 1;
    setup.error_term         = (dmin19 <<< 1) - dmaj19;
    setup.diagonal_increment = (dmin19 - dmaj19) <<< 1;
    setup.steps_left         = dmaj;
    setup.held_color         = item.line_color;
  end

endmodule

@@ rtl/clr_step.sv @@
// One Bresenham step: next line state and the pixel it emits, with clip flag.
// Depends on clr_pkg.
module clr_step (
  input  clr_pkg::line_state_t cur,
  output clr_pkg::line_state_t nxt,
  output clr_pkg::pixel_t      pixel
);

  logic signed [16:0] minor_new, px, py;

  always_comb begin
    nxt = cur;
    minor_new = cur.minor_pos;
    if (cur.error_term > 19'sd0) begin
      nxt.error_term = cur.error_term + cur.diagonal_increment;
      minor_new = cur.minor_pos + (cur.minor_negative ? -17'sd1 : 17'sd1);
    end else begin
      nxt.error_term = cur.error_term + cur.straight_increment;
    end
    nxt.minor_pos  = minor_new;
    nxt.major_pos  = cur.major_pos + (cur.major_negative ? -17'sd1 : 17'sd1);
    nxt.steps_left = cur.steps_left - 16'd1;

    px = cur.axes_swapped ? minor_new : cur.major_pos;
    py = cur.axes_swapped ? cur.major_pos : minor_new;

    pixel.pixel_x     = px[15:0];
    pixel.pixel_y     = py[15:0];
    pixel.pixel_color = cur.held_color;
    pixel.visible     = (px > clr_pkg::X_LO) && (px < clr_pkg::X_HI) &&
                        (py > clr_pkg::Y_LO) && (py < clr_pkg::Y_HI);
    pixel.last        = cur.steps_left == 16'd1;
  end

endmodule

@@ rtl/clipped_line_rasterizer.sv @@
// Clipped line rasteriser top level: line state register, setup and step logic,
// pixel output register. Depends on clr_pkg, clr_setup, clr_step and the defines header.
// A pixel is offered in the cycle after its tick item is accepted.
// Throughput: one item per cycle while the pixel output is not stalled.
// An item is taken while a pixel waits whenever that pixel is taken in the same cycle.
// Reset (synchronous) clears the line state, so ticks emit nothing until a load.
`include "clipped_line_rasterizer_defines.svh"

module clipped_line_rasterizer (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  clr_pkg::item_t  item,
  output logic            pixel_valid,
  input  logic            pixel_ready,
  output clr_pkg::pixel_t pixel
);

  clr_pkg::line_state_t line_state, line_state_next, setup_state, step_state;
  clr_pkg::pixel_t      step_pixel;
  logic                 item_accept, emit, pixel_valid_next;

  clr_setup u_setup (
    .item  (item),
    .setup (setup_state)
  );

  clr_step u_step (
    .cur   (line_state),
    .nxt   (step_state),
    .pixel (step_pixel)
  );

  assign item_ready  = !pixel_valid || pixel_ready;
  assign item_accept = item_valid && item_ready;
  assign emit = item_accept && (item.func == clr_pkg::FUNC_TICK) &&
                (line_state.steps_left != 16'd0);

  always_comb begin
    line_state_next = line_state;
    if (item_accept) begin
      if (item.func == clr_pkg::FUNC_LOAD) begin
        line_state_next = setup_state;
      end else if (emit) begin
        line_state_next = step_state;
      end
    end
    pixel_valid_next = emit || (pixel_valid && !pixel_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_state  <= '0;
      pixel_valid <= 1'b0;
    end else begin
      line_state  <= line_state_next;
      pixel_valid <= pixel_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel <= step_pixel;
    end
  end

  `CLR_ASSERT_NOW(a_ready_when_empty, !pixel_valid, item_ready, "ready low with empty output")
  `CLR_ASSERT_NEXT(a_load_no_pixel, item_accept && (item.func == clr_pkg::FUNC_LOAD), pixel_valid == $past(pixel_valid && !pixel_ready), "load item produced a pixel")
  `CLR_ASSERT_NEXT(a_step_count, emit, line_state.steps_left == $past(line_state.steps_left) - 16'd1, "steps_left not decremented by one")
  `CLR_ASSERT_NEXT(a_last_pixel, emit && (line_state.steps_left == 16'd1), pixel_valid && pixel.last && (line_state.steps_left == 16'd0), "final pixel not flagged last")

endmodule

@@ sim/tb.sv @@
// Testbench for the clipped line rasteriser: drives load and tick items, predicts each
// pixel with its own Bresenham model and checks the pixel stream pixel by pixel.
// Depends on clr_pkg and the clipped_line_rasterizer top level.
module tb;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;

  class pixel_scoreboard;
    clr_pkg::line_state_t line;
    clr_pkg::pixel_t      pixel_q[$];
    int                   errors;

    function new();
      line   = '0;
      errors = 0;
    endfunction

    task report(input string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    // Advance the line model by one accepted item and queue any pixel it yields.
    task note_item(input clr_pkg::item_t it);
      int              x0, y0, x1, y1, dx, dy, dmaj, dmin, px, py;
      bit              xneg, yneg;
      clr_pkg::pixel_t p;
      if (it.func == clr_pkg::FUNC_LOAD) begin
        x0 = it.x_start;
        y0 = it.y_start;
        x1 = it.x_end;
        y1 = it.y_end;
        xneg = x1 < x0;
        yneg = y1 < y0;
        dx = xneg ? x0 - x1 : x1 - x0;
        dy = yneg ? y0 - y1 : y1 - y0;
        line.held_color = it.line_color;
        if (dy < dx) begin
          line.axes_swapped   = 1'b0;
          line.major_negative = xneg;
          line.minor_negative = yneg;
          line.major_pos      = 17'(x0);
          line.minor_pos      = 17'(y0);
          dmaj = dx;
          dmin = dy;
        end else begin
          line.axes_swapped   = 1'b1;
          line.major_negative = yneg;
          line.minor_negative = xneg;
          line.major_pos      = 17'(y0);
          line.minor_pos      = 17'(x0);
          dmaj = dy;
          dmin = dx;
        end
        line.major_pos          = line.major_pos + (line.major_negative ? -17'sd1 : 17'sd1);
        line.error_term         = 19'(dmin * 2 - dmaj);
        line.straight_increment = 19'(dmin * 2);
        line.diagonal_increment = 19'((dmin - dmaj) * 2);
        line.steps_left         = 16'(dmaj);
        return;
      end
      if (line.steps_left == 0) return;
      if (line.error_term > 0) begin
        line.error_term = line.error_term + line.diagonal_increment;
        line.minor_pos  = line.minor_pos + (line.minor_negative ? -17'sd1 : 17'sd1);
      end else begin
        line.error_term = line.error_term + line.straight_increment;
      end
      px = line.axes_swapped ? line.minor_pos : line.major_pos;
      py = line.axes_swapped ? line.major_pos : line.minor_pos;
      line.steps_left = line.steps_left - 16'd1;
      p.pixel_x     = 16'(px);
      p.pixel_y     = 16'(py);
      p.pixel_color = line.held_color;
      p.visible     = px > clr_pkg::WINDOW_WIDTH / 5 &&
                      px < clr_pkg::WINDOW_WIDTH - clr_pkg::WINDOW_WIDTH / 5 &&
                      py > clr_pkg::WINDOW_HEIGHT / 5 &&
                      py < clr_pkg::WINDOW_HEIGHT - clr_pkg::WINDOW_HEIGHT / 5;
      p.last        = line.steps_left == 0;
      pixel_q.push_back(p);
      line.major_pos = line.major_pos + (line.major_negative ? -17'sd1 : 17'sd1);
    endtask

    task check_pixel(input clr_pkg::pixel_t got);
      clr_pkg::pixel_t want;
      if (pixel_q.size() == 0) begin
        report($sformatf("pixel (%0d,%0d) with none pending", got.pixel_x, got.pixel_y));
        return;
      end
      want = pixel_q.pop_front();
      if (got.pixel_x !== want.pixel_x)
        report($sformatf("pixel_x %0d, want %0d", got.pixel_x, want.pixel_x));
      if (got.pixel_y !== want.pixel_y)
        report($sformatf("pixel_y %0d, want %0d", got.pixel_y, want.pixel_y));
      if (got.pixel_color !== want.pixel_color)
        report($sformatf("pixel_color %h, want %h", got.pixel_color, want.pixel_color));
      if (got.visible !== want.visible)
        report($sformatf("visible %b, want %b at (%0d,%0d)", got.visible, want.visible,
                         want.pixel_x, want.pixel_y));
      if (got.last !== want.last)
        report($sformatf("last %b, want %b at (%0d,%0d)", got.last, want.last,
                         want.pixel_x, want.pixel_y));
    endtask
  endclass

  logic            clk;
  logic            rst         = 1'b1;
  logic            item_valid  = 1'b0;
  logic            item_ready;
  clr_pkg::item_t  item        = '0;
  logic            pixel_valid;
  logic            pixel_ready = 1'b0;
  clr_pkg::pixel_t pixel;

  pixel_scoreboard sb = new();
  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int cycle_count = 0;

  clipped_line_rasterizer DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic clr_pkg::item_t tick_item();
    clr_pkg::item_t it;
    it.func       = clr_pkg::FUNC_TICK;
    it.x_start    = 16'($urandom);
    it.y_start    = 16'($urandom);
    it.x_end      = 16'($urandom);
    it.y_end      = 16'($urandom);
    it.line_color = 24'($urandom);
    return it;
  endfunction

  function automatic clr_pkg::item_t load_item(input int x0, y0, x1, y1,
                                               input logic [23:0] colour);
    clr_pkg::item_t it;
    it.func       = clr_pkg::FUNC_LOAD;
    it.x_start    = 16'(x0);
    it.y_start    = 16'(y0);
    it.x_end      = 16'(x1);
    it.y_end      = 16'(y1);
    it.line_color = colour;
    return it;
  endfunction

  task automatic send_item(input clr_pkg::item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    sb.note_item(it);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(tick_item());
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (sb.pixel_q.size() != 0) @(posedge clk);
  endtask

  task automatic directed_items();
    send_ticks(1);
    send_item(load_item(5, 5, 5, 5, 24'h123456));
    send_ticks(1);
    send_item(load_item(-32768, -32768, 32767, 32767, 24'hFFFFFF));
    send_ticks(2);
    send_item(load_item(32767, -32768, -32768, 32767, 24'h000000));
    send_ticks(2);
    send_item(load_item(203, 300, 208, 302, 24'hAA55AA));
    send_ticks(6);
    send_item(load_item(500, 617, 499, 612, 24'h55AA55));
    send_ticks(5);
    send_item(load_item(820, 152, 818, 156, 24'h0F0F0F));
    send_ticks(4);
  endtask

  task automatic random_items();
    int             counted, n, r, x0, y0, x1, y1, span;
    bit             hold_done, drain_done;
    clr_pkg::item_t it;
    counted    = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    while (counted < 450) begin
      calm = $urandom_range(0, 7) == 0;
      if (counted >= 150 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (counted >= 300 && !drain_done) begin
        wait_drained();
        drain_done = 1'b1;
      end
      r = $urandom_range(0, 9);
      if (r == 9) begin
        // noise: random items, loads and ticks mixed
        repeat ($urandom_range(1, 4)) begin
          it = tick_item();
          it.func = 1'($urandom_range(0, 1));
          if (it.func == clr_pkg::FUNC_LOAD || sb.line.steps_left != 0) counted++;
          send_item(it);
        end
      end else begin
        if (r < 7) begin
          span = ($urandom_range(0, 4) == 0) ? 80 : 20;
          x0 = $urandom_range(0, 1100);
          x0 -= 30;
          y0 = $urandom_range(0, 850);
          y0 -= 30;
          x1 = $urandom_range(0, 2 * span);
          x1 += x0 - span;
          y1 = $urandom_range(0, 2 * span);
          y1 += y0 - span;
          it = load_item(x0, y0, x1, y1, 24'($urandom));
        end else begin
          it = tick_item();
          it.func = clr_pkg::FUNC_LOAD;
        end
        send_item(it);
        counted++;
        if (sb.line.steps_left <= 200) n = sb.line.steps_left + $urandom_range(0, 2);
        else n = $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
        repeat (n) begin
          if (sb.line.steps_left != 0) counted++;
          send_item(tick_item());
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin : pixel_sink
    int   run_left, hold_left;
    logic rdy;
    run_left  = 0;
    hold_left = 0;
    rdy       = 1'b1;
    forever begin
      @(posedge clk);
      if (pixel_valid && pixel_ready) sb.check_pixel(pixel);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pixel_ready <= 1'b0;
      end else if (calm) begin
        pixel_ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          rdy = $urandom_range(0, 2) != 0;
          run_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 40);
        end
        run_left--;
        pixel_ready <= rdy;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_items();
    random_items();
    item_valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pixel_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
